FILE: design/summed_area_table_rect_sum_assert.svh
// Assertion macros for the summed-area table block.
`ifndef SUMMED_AREA_TABLE_RECT_SUM_ASSERT_SVH
`define SUMMED_AREA_TABLE_RECT_SUM_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sat_pkg.sv
`default_nettype none
package sat_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COORD_W    = 8;
  localparam int PIXEL_W    = 8;
  localparam int DIM_W      = 9;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int ENTRY_W    = 24;
  localparam int RSUM_W     = 16;
  localparam int AVG_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int AREA_W     = 17;
  localparam int DVD_W      = ENTRY_W + 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LOADED = 2'd1,
    ST_RANGE      = 2'd2
  } status_t;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  above_addr;
    logic               has_above;
    logic [RSUM_W-1:0]  row_sum;
  } load_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } q_status_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] rect_sum;
    logic [AVG_W-1:0]   rect_average_q8;
    status_t            status;
  } result_t;

endpackage
`default_nettype wire

FILE: design/sat_in_if.sv
`default_nettype none
interface sat_in_if;
  import sat_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [PIXEL_W-1:0] pixel;
  logic [COORD_W-1:0] corner_a_x;
  logic [COORD_W-1:0] corner_a_y;
  logic [COORD_W-1:0] corner_b_x;
  logic [COORD_W-1:0] corner_b_y;

  modport source (
    output valid, op, pixel, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
    input  ready
  );

  modport sink (
    input  valid, op, pixel, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
    output ready
  );
endinterface
`default_nettype wire

FILE: design/sat_out_if.sv
`default_nettype none
interface sat_out_if;
  import sat_pkg::*;

  logic                valid;
  logic                ready;
  logic [ENTRY_W-1:0]  rect_sum;
  logic [AVG_W-1:0]    rect_average_q8;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, rect_sum, rect_average_q8, status,
    input  ready
  );

  modport sink (
    input  valid, rect_sum, rect_average_q8, status,
    output ready
  );
endinterface
`default_nettype wire

FILE: design/summed_area_table_rect_sum.sv
// Pixel items: one per cycle, back to back while no query is busy; each table entry is
//   written in the cycle after its item, while the one read port of the table fetches the entry above.
// Query items: an error status goes straight to the output register; an ok result
//   first takes four reads on the one table port and a 32-step bit-serial divider.
// Reset: width and height 256, load position (0,0), frame not loaded, output empty.
//   The table memory is not cleared; entries are undefined until written.
`default_nettype none
`include "summed_area_table_rect_sum_assert.svh"
module summed_area_table_rect_sum (
  input  logic                           clk,
  input  logic                           rst_n,
  sat_in_if.sink                         in_if,
  sat_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sat_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sat_pkg::*;

  logic [DIM_W-1:0]   image_width_r;
  logic [DIM_W-1:0]   image_height_r;
  logic [DIM_W-1:0]   width_c;
  logic [DIM_W-1:0]   height_c;

  logic               restart;
  logic               in_acc;
  logic               pixel_acc;
  logic               query_start;
  logic               frame_loaded;
  logic               out_free;

  load_req_t          ld_req;
  rd_req_t            rd_req;
  q_status_t          q_stat;
  result_t            q_res;
  logic [ENTRY_W-1:0] rd_data;

  logic               out_valid_r;
  result_t            out_res_r;

  always_comb begin
    if (image_width_r == '0) begin
      width_c = DIM_W'(1);
    end else if (image_width_r > DIM_W'(MAX_WIDTH)) begin
      width_c = DIM_W'(MAX_WIDTH);
    end else begin
      width_c = image_width_r;
    end
    if (image_height_r == '0) begin
      height_c = DIM_W'(1);
    end else if (image_height_r > DIM_W'(MAX_HEIGHT)) begin
      height_c = DIM_W'(MAX_HEIGHT);
    end else begin
      height_c = image_height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_W'(MAX_WIDTH);
      image_height_r <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    restart     = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                             (cfg_index == REG_IMAGE_HEIGHT));
    in_if.ready = !q_stat.busy;
    in_acc      = in_if.valid && in_if.ready;
    pixel_acc   = in_acc && (in_if.op == OP_LOAD);
    query_start = in_acc && (in_if.op == OP_QUERY);
    out_free    = !out_valid_r || out_if.ready;
  end

  sat_loader u_loader (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_acc    (pixel_acc),
    .pixel        (in_if.pixel),
    .restart      (restart),
    .width        (width_c),
    .height       (height_c),
    .ld_req       (ld_req),
    .frame_loaded (frame_loaded)
  );

  sat_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_req  (ld_req),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  sat_query u_query (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (query_start),
    .ax           (in_if.corner_a_x),
    .ay           (in_if.corner_a_y),
    .bx           (in_if.corner_b_x),
    .by           (in_if.corner_b_y),
    .width        (width_c),
    .height       (height_c),
    .frame_loaded (frame_loaded),
    .rd_data      (rd_data),
    .out_free     (out_free),
    .rd_req       (rd_req),
    .q_stat       (q_stat),
    .res          (q_res)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_stat.res_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_stat.res_valid && out_free) begin
      out_res_r <= q_res;
    end
  end

  always_comb begin
    out_if.valid           = out_valid_r;
    out_if.rect_sum        = out_res_r.rect_sum;
    out_if.rect_average_q8 = out_res_r.rect_average_q8;
    out_if.status          = out_res_r.status;
  end

  `SAT_ASSERT_NEXT(a_query_holds_input, query_start, q_stat.busy, "query did not take the input")
  `SAT_ASSERT_NOW(a_port_exclusive, rd_req.en, !ld_req.valid, "table port claimed twice")
  `SAT_ASSERT_NEXT(a_restart_clears, restart, !frame_loaded, "frame still loaded after restart")
  `SAT_ASSERT_NOW(a_error_zero, out_valid_r && (out_res_r.status != ST_OK), (out_res_r.rect_sum == '0) && (out_res_r.rect_average_q8 == '0), "error result not zero")

endmodule
`default_nettype wire

FILE: design/sat_loader.sv
`default_nettype none
module sat_loader (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pixel_acc,
  input  logic [sat_pkg::PIXEL_W-1:0] pixel,
  input  logic                        restart,
  input  logic [sat_pkg::DIM_W-1:0]   width,
  input  logic [sat_pkg::DIM_W-1:0]   height,
  output sat_pkg::load_req_t          ld_req,
  output logic                        frame_loaded
);
  import sat_pkg::*;

  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [RSUM_W-1:0]  rsum_r, rsum_nxt;
  logic               loaded_r, loaded_nxt;

  logic               wrap_c;
  logic [COORD_W-1:0] col_c;
  logic [COORD_W-1:0] row_c;
  logic [RSUM_W-1:0]  rsum_c;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;

  always_comb begin
    wrap_c  = loaded_r || ({1'b0, col_r} >= width) || ({1'b0, row_r} >= height);
    col_c   = wrap_c ? '0 : col_r;
    row_c   = wrap_c ? '0 : row_r;
    rsum_c  = (col_c == '0) ? RSUM_W'(pixel) : rsum_r + RSUM_W'(pixel);
    col_inc = {1'b0, col_c} + DIM_W'(1);
    row_inc = {1'b0, row_c} + DIM_W'(1);

    col_nxt    = col_r;
    row_nxt    = row_r;
    rsum_nxt   = rsum_r;
    loaded_nxt = loaded_r;
    if (restart) begin
      col_nxt    = '0;
      row_nxt    = '0;
      rsum_nxt   = '0;
      loaded_nxt = 1'b0;
    end else if (pixel_acc) begin
      rsum_nxt   = rsum_c;
      loaded_nxt = 1'b0;
      if (col_inc >= width) begin
        col_nxt = '0;
        if (row_inc >= height) begin
          row_nxt    = '0;
          loaded_nxt = 1'b1;
        end else begin
          row_nxt = row_inc[COORD_W-1:0];
        end
      end else begin
        col_nxt = col_inc[COORD_W-1:0];
        row_nxt = row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      rsum_r   <= '0;
      loaded_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rsum_r   <= rsum_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  always_comb begin
    ld_req.valid      = pixel_acc && !restart;
    ld_req.addr       = {row_c, col_c};
    ld_req.above_addr = {row_c - COORD_W'(1), col_c};
    ld_req.has_above  = (row_c != '0);
    ld_req.row_sum    = rsum_c;
  end

  assign frame_loaded = loaded_r;

endmodule
`default_nettype wire

FILE: design/sat_store.sv
`default_nettype none
module sat_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sat_pkg::load_req_t          ld_req,
  input  sat_pkg::rd_req_t            rd_req,
  output logic [sat_pkg::ENTRY_W-1:0] rd_data
);
  import sat_pkg::*;

  logic [ENTRY_W-1:0] area_mem [2**ADDR_W];
  logic [ENTRY_W-1:0] rdata_r;

  logic               pend_v_r;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic [RSUM_W-1:0]  pend_rsum_r;
  logic               pend_above_r;
  logic               fwd_r;
  logic [ENTRY_W-1:0] fwd_data_r;

  logic [ENTRY_W-1:0] above_c;
  logic [ENTRY_W-1:0] entry_c;
  logic               rd_en_c;
  logic [ADDR_W-1:0]  rd_addr_c;

  always_comb begin
    above_c   = pend_above_r ? (fwd_r ? fwd_data_r : rdata_r) : '0;
    entry_c   = ENTRY_W'(pend_rsum_r) + above_c;
    rd_en_c   = ld_req.valid || rd_req.en;
    rd_addr_c = ld_req.valid ? ld_req.above_addr : rd_req.addr;
  end

  // table port: write the pending entry, read the next one
  always_ff @(posedge clk) begin
    if (pend_v_r) begin
      area_mem[pend_addr_r] <= entry_c;
    end
    if (rd_en_c) begin
      rdata_r <= area_mem[rd_addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else begin
      pend_v_r <= ld_req.valid;
    end
  end

  // bypass the entry being written when the next item reads it
  always_ff @(posedge clk) begin
    if (ld_req.valid) begin
      pend_addr_r  <= ld_req.addr;
      pend_rsum_r  <= ld_req.row_sum;
      pend_above_r <= ld_req.has_above;
      fwd_r        <= pend_v_r && (ld_req.above_addr == pend_addr_r);
      fwd_data_r   <= entry_c;
    end
  end

  assign rd_data = rdata_r;

endmodule
`default_nettype wire

FILE: design/sat_div.sv
`default_nettype none
module sat_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sat_pkg::DVD_W-1:0]  dividend,
  input  logic [sat_pkg::AREA_W-1:0] divisor,
  output logic                      done,
  output logic [sat_pkg::DVD_W-1:0]  quotient
);
  import sat_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [AREA_W-1:0] dsr_r;
  logic [AREA_W-1:0] rem_r;

  logic [AREA_W:0]  rem_sh;
  logic [AREA_W:0]  rem_sub;
  logic             ge_c;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    ge_c    = rem_sh >= {1'b0, dsr_r};
    rem_sub = ge_c ? rem_sh - {1'b0, dsr_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per step, shifted into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge_c};
      rem_r <= rem_sub[AREA_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

FILE: design/sat_query.sv
`default_nettype none
module sat_query (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sat_pkg::COORD_W-1:0] ax,
  input  logic [sat_pkg::COORD_W-1:0] ay,
  input  logic [sat_pkg::COORD_W-1:0] bx,
  input  logic [sat_pkg::COORD_W-1:0] by,
  input  logic [sat_pkg::DIM_W-1:0]   width,
  input  logic [sat_pkg::DIM_W-1:0]   height,
  input  logic                        frame_loaded,
  input  logic [sat_pkg::ENTRY_W-1:0] rd_data,
  input  logic                        out_free,
  output sat_pkg::rd_req_t            rd_req,
  output sat_pkg::q_status_t          q_stat,
  output sat_pkg::result_t            res
);
  import sat_pkg::*;

  typedef enum logic [2:0] {Q_IDLE, Q_READ, Q_DRAIN, Q_DIV, Q_DONE} q_state_t;

  localparam logic [1:0] TERM_HH = 2'd0;
  localparam logic [1:0] TERM_LH = 2'd1;
  localparam logic [1:0] TERM_HL = 2'd2;
  localparam logic [1:0] TERM_LL = 2'd3;

  q_state_t           state_r;
  logic [1:0]         idx_r;
  logic [1:0]         prev_idx_r;
  logic               prev_v_r;
  logic [COORD_W-1:0] x0_r, x1_r, y0_r, y1_r;
  logic [DIM_W-1:0]   dx_r, dy_r;
  logic [AREA_W-1:0]  area_r;
  logic [ENTRY_W-1:0] sum_r;
  logic [AVG_W-1:0]   avg_r;
  status_t            status_r;

  logic [COORD_W-1:0] x0_c, x1_c, y0_c, y1_c;
  logic               range_err_c;
  logic [ENTRY_W-1:0] term_c;
  logic               sub_c;
  logic [ENTRY_W-1:0] sum_acc_c;
  logic [2*DIM_W-1:0] prod_c;
  logic               div_start;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;

  always_comb begin
    x0_c = (ax < bx) ? ax : bx;
    x1_c = (ax < bx) ? bx : ax;
    y0_c = (ay < by) ? ay : by;
    y1_c = (ay < by) ? by : ay;
    range_err_c = ({1'b0, ax} >= width) || ({1'b0, bx} >= width) ||
                  ({1'b0, ay} >= height) || ({1'b0, by} >= height);
    prod_c = (2*DIM_W)'(dx_r) * (2*DIM_W)'(dy_r);
  end

  always_comb begin
    rd_req.en = (state_r == Q_READ);
    case (idx_r)
      TERM_HH: rd_req.addr = {y1_r, x1_r};
      TERM_LH: rd_req.addr = {y0_r - COORD_W'(1), x1_r};
      TERM_HL: rd_req.addr = {y1_r, x0_r - COORD_W'(1)};
      TERM_LL: rd_req.addr = {y0_r - COORD_W'(1), x0_r - COORD_W'(1)};
      default: rd_req.addr = {y1_r, x1_r};
    endcase
  end

  // drop terms that fall on row or column -1
  always_comb begin
    case (prev_idx_r)
      TERM_HH: begin
        term_c = rd_data;
        sub_c  = 1'b0;
      end
      TERM_LH: begin
        term_c = (y0_r != '0) ? rd_data : '0;
        sub_c  = 1'b1;
      end
      TERM_HL: begin
        term_c = (x0_r != '0) ? rd_data : '0;
        sub_c  = 1'b1;
      end
      TERM_LL: begin
        term_c = ((y0_r != '0) && (x0_r != '0)) ? rd_data : '0;
        sub_c  = 1'b0;
      end
      default: begin
        term_c = '0;
        sub_c  = 1'b0;
      end
    endcase
    if (prev_v_r) begin
      sum_acc_c = sub_c ? sum_r - term_c : sum_r + term_c;
    end else begin
      sum_acc_c = sum_r;
    end
  end

  assign div_start = (state_r == Q_DRAIN);

  sat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_acc_c, 8'd0}),
    .divisor  (area_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= Q_IDLE;
      prev_v_r <= 1'b0;
      idx_r    <= TERM_HH;
    end else begin
      case (state_r)
        Q_IDLE: begin
          prev_v_r <= 1'b0;
          idx_r    <= TERM_HH;
          if (start) begin
            x0_r  <= x0_c;
            x1_r  <= x1_c;
            y0_r  <= y0_c;
            y1_r  <= y1_c;
            dx_r  <= {1'b0, x1_c} - {1'b0, x0_c} + DIM_W'(1);
            dy_r  <= {1'b0, y1_c} - {1'b0, y0_c} + DIM_W'(1);
            sum_r <= '0;
            avg_r <= '0;
            if (!frame_loaded) begin
              status_r <= ST_NOT_LOADED;
              state_r  <= Q_DONE;
            end else if (range_err_c) begin
              status_r <= ST_RANGE;
              state_r  <= Q_DONE;
            end else begin
              status_r <= ST_OK;
              state_r  <= Q_READ;
            end
          end
        end
        Q_READ: begin
          area_r     <= prod_c[AREA_W-1:0];
          sum_r      <= sum_acc_c;
          prev_v_r   <= 1'b1;
          prev_idx_r <= idx_r;
          idx_r      <= idx_r + 2'd1;
          if (idx_r == TERM_LL) begin
            state_r <= Q_DRAIN;
          end
        end
        Q_DRAIN: begin
          sum_r    <= sum_acc_c;
          prev_v_r <= 1'b0;
          state_r  <= Q_DIV;
        end
        Q_DIV: begin
          if (div_done) begin
            avg_r   <= div_q[AVG_W-1:0];
            state_r <= Q_DONE;
          end
        end
        Q_DONE: begin
          if (out_free) begin
            state_r <= Q_IDLE;
          end
        end
        default: state_r <= Q_IDLE;
      endcase
    end
  end

  always_comb begin
    q_stat.busy          = (state_r != Q_IDLE);
    q_stat.res_valid     = (state_r == Q_DONE);
    res.rect_sum         = sum_r;
    res.rect_average_q8  = avg_r;
    res.status           = status_r;
  end

endmodule
`default_nettype wire
